>>> src/stq_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the sorted timer queue
// no dependencies

package stq_pkg;

    localparam int HANDLE_W    = 4;
    localparam int NUM_HANDLES = 16;
    localparam int IN_TIME_W   = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_ADJUST = 2'd1,
        OP_DELETE = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STATUS_DONE    = 3'd0,
        STATUS_EXPIRED = 3'd1,
        STATUS_NONE    = 3'd2,
        STATUS_FULL    = 3'd3,
        STATUS_UNKNOWN = 3'd4,
        STATUS_DUP     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP_START,
        ST_CMP_WALK,
        ST_CMP_END,
        ST_INS_START,
        ST_INS_WALK,
        ST_RESP
    } state_t;

    // one result handed from the sequencer to the output register
    typedef struct packed {
        logic                valid;
        logic [HANDLE_W-1:0] handle;
        status_t             status;
        logic                last;
    } emit_t;

endpackage

>>> src/sorted_timer_queue.sv
`timescale 1ns / 1ps
// sorted timer queue top level: sequencer, list ram and result register
// depends on stq_pkg, stq_ram, stq_seq
//
// usage:
//   command channel (cmd_valid/cmd_ready) carries one request: operation,
//   timer_handle, expire_time (add, adjust) and now_time (tick).
//   result channel (result_valid/result_ready) carries result_handle,
//   status and last; last marks the final result of a request.
//   the list lives in a ram of min(CAPACITY, 16) entries sorted by expiry,
//   equal expiries first in, first out. one shared expiry comparator walks
//   the ram one entry a cycle, unless stalled, through its registered read port.
// request flow:
//   add walks the list from its end to the insert point, delete and tick
//   walk the whole list, adjust does both walks; cmd_ready returns once
//   the final result has entered the result register.
//   rejected requests (duplicate, full, unknown handle) answer straight
//   from the idle state without a walk.
//   a receiver that holds off a due result delays the request.
//   one request is in work at a time; cmd_ready is high only when idle.
// reset clears the entry count and the per-handle queued flags; the ram
// itself needs no clearing pass since only positions below the count are
// read. a stalled receiver holds the result register and the walk waits.

module sorted_timer_queue #(
    parameter int CAPACITY   = 16,
    parameter int TIME_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  logic [1:0]                         operation,
    input  logic [stq_pkg::HANDLE_W-1:0]       timer_handle,
    input  logic [stq_pkg::IN_TIME_W-1:0]      expire_time,
    input  logic [stq_pkg::IN_TIME_W-1:0]      now_time,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [stq_pkg::HANDLE_W-1:0]       result_handle,
    output logic [2:0]                         status,
    output logic                               last
);

    // never more timers than handles
    localparam int DEPTH = (CAPACITY < stq_pkg::NUM_HANDLES) ? CAPACITY : stq_pkg::NUM_HANDLES;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = stq_pkg::HANDLE_W + TIME_WIDTH;

    stq_pkg::emit_t                 emit;
    logic                           out_free;
    logic                           ram_wr_en;
    logic [AW-1:0]                  ram_wr_addr;
    logic [DW-1:0]                  ram_wr_data;
    logic [AW-1:0]                  ram_rd_addr;
    logic [DW-1:0]                  ram_rd_data;

    logic                           result_valid_reg, result_valid_next;
    logic [stq_pkg::HANDLE_W-1:0]   result_handle_reg;
    logic [2:0]                     status_reg;
    logic                           last_reg;

    // result register takes a new result when empty or being drained
    assign out_free = !result_valid_reg || result_ready;

    stq_seq #(
        .DEPTH      (DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .operation    (operation),
        .timer_handle (timer_handle),
        .expire_time  (expire_time),
        .now_time     (now_time),
        .out_free     (out_free),
        .emit         (emit),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    stq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_list_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (emit.valid)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    // payload of the result register
    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            result_handle_reg <= emit.handle;
            status_reg        <= emit.status;
            last_reg          <= emit.last;
        end
    end

    assign result_valid  = result_valid_reg;
    assign result_handle = result_handle_reg;
    assign status        = status_reg;
    assign last          = last_reg;

endmodule

>>> src/stq_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module stq_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/stq_seq.sv
`timescale 1ns / 1ps
// sequencer for the sorted timer queue: walks the list ram one entry a cycle unless stalled
// depends on stq_pkg; drives an stq_ram instance held by the top level

module stq_seq #(
    parameter int DEPTH      = 16,
    parameter int TIME_WIDTH = 32
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cmd_valid,
    output logic                                       cmd_ready,
    input  logic [1:0]                                 operation,
    input  logic [stq_pkg::HANDLE_W-1:0]               timer_handle,
    input  logic [stq_pkg::IN_TIME_W-1:0]              expire_time,
    input  logic [stq_pkg::IN_TIME_W-1:0]              now_time,
    input  logic                                       out_free,
    output stq_pkg::emit_t                             emit,
    output logic                                       ram_wr_en,
    output logic [$clog2(DEPTH)-1:0]                   ram_wr_addr,
    output logic [stq_pkg::HANDLE_W+TIME_WIDTH-1:0]    ram_wr_data,
    output logic [$clog2(DEPTH)-1:0]                   ram_rd_addr,
    input  logic [stq_pkg::HANDLE_W+TIME_WIDTH-1:0]    ram_rd_data
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IN_W = (TIME_WIDTH < stq_pkg::IN_TIME_W) ? TIME_WIDTH : stq_pkg::IN_TIME_W;

    stq_pkg::state_t                    state_reg, state_next;
    stq_pkg::op_t                       op_reg, op_next;
    logic [stq_pkg::HANDLE_W-1:0]       h_reg, h_next;
    logic [TIME_WIDTH-1:0]              t_reg, t_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [CW-1:0]                      idx_reg, idx_next;
    logic [CW-1:0]                      wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]                      pos_reg, pos_next;
    logic [stq_pkg::HANDLE_W-1:0]       prev_reg, prev_next;
    logic                               prev_valid_reg, prev_valid_next;
    logic                               popping_reg, popping_next;
    logic                               any_pop_reg, any_pop_next;
    logic [stq_pkg::NUM_HANDLES-1:0]    queued_reg, queued_next;
    logic [stq_pkg::HANDLE_W-1:0]       resp_handle_reg, resp_handle_next;
    stq_pkg::status_t                   resp_status_reg, resp_status_next;

    logic [stq_pkg::HANDLE_W-1:0]       data_handle;
    logic [TIME_WIDTH-1:0]              data_exp;
    logic                               later;
    logic                               is_tick;
    logic                               pop;
    logic                               keep;
    logic                               emit_due;
    logic                               stall;
    logic                               at_end;
    logic                               shift_up;
    logic                               full;
    logic [CW-1:0]                      idx_inc;
    logic [CW-1:0]                      pos_dec2;
    logic [CW-1:0]                      count_dec;

    assign data_handle = ram_rd_data[stq_pkg::HANDLE_W+TIME_WIDTH-1:TIME_WIDTH];
    assign data_exp    = ram_rd_data[TIME_WIDTH-1:0];

    // the shared compare unit: entry expiry against the latched time
    assign later    = data_exp > t_reg;

    assign is_tick  = op_reg == stq_pkg::OP_TICK;
    assign pop      = is_tick && popping_reg && !later;
    assign keep     = is_tick ? !pop : (data_handle != h_reg);
    assign emit_due = is_tick && prev_valid_reg && popping_reg;
    assign stall    = emit_due && !out_free;
    assign count_dec = count_reg - CW'(1);
    assign at_end   = idx_reg == count_dec;
    assign shift_up = (pos_reg != '0) && later;
    assign full     = count_reg >= CW'(DEPTH);
    assign idx_inc  = idx_reg + CW'(1);
    assign pos_dec2 = pos_reg - CW'(2);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (stq_pkg::op_t'(operation)) inside
                        stq_pkg::OP_ADD:
                        begin
                            if (queued_reg[timer_handle] || full)
                                state_next = stq_pkg::ST_RESP;
                            else
                                state_next = stq_pkg::ST_INS_START;
                        end
                        stq_pkg::OP_ADJUST, stq_pkg::OP_DELETE:
                        begin
                            if (!queued_reg[timer_handle])
                                state_next = stq_pkg::ST_RESP;
                            else
                                state_next = stq_pkg::ST_CMP_START;
                        end
                        default:
                        begin
                            state_next = stq_pkg::ST_CMP_START;
                        end
                    endcase
                end
            end
            stq_pkg::ST_CMP_START:
            begin
                state_next = (count_reg == '0) ? stq_pkg::ST_CMP_END : stq_pkg::ST_CMP_WALK;
            end
            stq_pkg::ST_CMP_WALK:
            begin
                if (!stall && at_end)
                    state_next = stq_pkg::ST_CMP_END;
            end
            stq_pkg::ST_CMP_END:
            begin
                if (is_tick)
                    state_next = (prev_valid_reg || !any_pop_reg) ?
                                 stq_pkg::ST_RESP : stq_pkg::ST_IDLE;
                else if (op_reg == stq_pkg::OP_ADJUST)
                    state_next = stq_pkg::ST_INS_START;
                else
                    state_next = stq_pkg::ST_RESP;
            end
            stq_pkg::ST_INS_START:
            begin
                state_next = stq_pkg::ST_INS_WALK;
            end
            stq_pkg::ST_INS_WALK:
            begin
                if (!shift_up)
                    state_next = stq_pkg::ST_RESP;
            end
            stq_pkg::ST_RESP:
            begin
                if (out_free)
                    state_next = stq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready        = 1'b0;
        emit             = '0;
        emit.status      = stq_pkg::STATUS_DONE;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = wr_ptr_reg[AW-1:0];
        ram_wr_data      = ram_rd_data;
        ram_rd_addr      = idx_reg[AW-1:0];
        op_next          = op_reg;
        h_next           = h_reg;
        t_next           = t_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        wr_ptr_next      = wr_ptr_reg;
        pos_next         = pos_reg;
        prev_next        = prev_reg;
        prev_valid_next  = prev_valid_reg;
        popping_next     = popping_reg;
        any_pop_next     = any_pop_reg;
        queued_next      = queued_reg;
        resp_handle_next = resp_handle_reg;
        resp_status_next = resp_status_reg;

        unique case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                cmd_ready        = 1'b1;
                op_next          = stq_pkg::op_t'(operation);
                h_next           = timer_handle;
                t_next           = (stq_pkg::op_t'(operation) == stq_pkg::OP_TICK) ?
                                   TIME_WIDTH'(now_time[IN_W-1:0]) :
                                   TIME_WIDTH'(expire_time[IN_W-1:0]);
                resp_handle_next = timer_handle;
                if (stq_pkg::op_t'(operation) == stq_pkg::OP_ADD)
                    resp_status_next = queued_reg[timer_handle] ? stq_pkg::STATUS_DUP :
                                       stq_pkg::STATUS_FULL;
                else
                    resp_status_next = stq_pkg::STATUS_UNKNOWN;
            end
            stq_pkg::ST_CMP_START:
            begin
                ram_rd_addr     = '0;
                idx_next        = '0;
                wr_ptr_next     = '0;
                prev_valid_next = 1'b0;
                popping_next    = 1'b1;
                any_pop_next    = 1'b0;
            end
            stq_pkg::ST_CMP_WALK:
            begin
                // pending popped handle goes out once the next entry shows whether it is last
                emit.valid  = emit_due && out_free;
                emit.handle = prev_reg;
                emit.status = stq_pkg::STATUS_EXPIRED;
                emit.last   = !pop;
                if (!stall)
                begin
                    ram_rd_addr = idx_inc[AW-1:0];
                    idx_next    = idx_inc;
                    if (keep)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = wr_ptr_reg[AW-1:0];
                        ram_wr_data = ram_rd_data;
                        wr_ptr_next = wr_ptr_reg + CW'(1);
                    end
                    if (pop)
                    begin
                        queued_next[data_handle] = 1'b0;
                        prev_next                = data_handle;
                        prev_valid_next          = 1'b1;
                        any_pop_next             = 1'b1;
                    end
                    else if (is_tick)
                    begin
                        popping_next = 1'b0;
                        if (emit_due)
                            prev_valid_next = 1'b0;
                    end
                end
            end
            stq_pkg::ST_CMP_END:
            begin
                count_next = wr_ptr_reg;
                if (is_tick)
                begin
                    resp_handle_next = prev_valid_reg ? prev_reg : '0;
                    resp_status_next = prev_valid_reg ? stq_pkg::STATUS_EXPIRED :
                                       stq_pkg::STATUS_NONE;
                end
                else
                begin
                    queued_next[h_reg] = 1'b0;
                    resp_handle_next   = h_reg;
                    resp_status_next   = stq_pkg::STATUS_DONE;
                end
            end
            stq_pkg::ST_INS_START:
            begin
                pos_next    = count_reg;
                ram_rd_addr = count_dec[AW-1:0];
            end
            stq_pkg::ST_INS_WALK:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg[AW-1:0];
                if (shift_up)
                begin
                    ram_wr_data = ram_rd_data;
                    pos_next    = pos_reg - CW'(1);
                    ram_rd_addr = pos_dec2[AW-1:0];
                end
                else
                begin
                    ram_wr_data        = {h_reg, t_reg};
                    count_next         = count_reg + CW'(1);
                    queued_next[h_reg] = 1'b1;
                    resp_handle_next   = h_reg;
                    resp_status_next   = stq_pkg::STATUS_DONE;
                end
            end
            stq_pkg::ST_RESP:
            begin
                emit.valid  = out_free;
                emit.handle = resp_handle_reg;
                emit.status = resp_status_reg;
                emit.last   = 1'b1;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= stq_pkg::ST_IDLE;
            count_reg      <= '0;
            queued_reg     <= '0;
            prev_valid_reg <= 1'b0;
            popping_reg    <= 1'b0;
            any_pop_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            queued_reg     <= queued_next;
            prev_valid_reg <= prev_valid_next;
            popping_reg    <= popping_next;
            any_pop_reg    <= any_pop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        h_reg           <= h_next;
        t_reg           <= t_next;
        idx_reg         <= idx_next;
        wr_ptr_reg      <= wr_ptr_next;
        pos_reg         <= pos_next;
        prev_reg        <= prev_next;
        resp_handle_reg <= resp_handle_next;
        resp_status_reg <= resp_status_next;
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the sorted timer queue: directed and random requests
// checked against a list model kept in the bench; depends on stq_pkg and sorted_timer_queue

module testbench;

    localparam int          LIST_DEPTH   = 16;
    // cycles with no handshake on either channel before the run is declared hung;
    // the limit lies well above an adjust on a full list and above a
    // 16-result tick under a 70 percent receiver stall
    localparam int          STALL_LIMIT  = 4000;
    // settle time after the last result, above the worst request latency
    localparam int          DRAIN_CYCLES = 64;
    localparam int          PHASE_ITEMS  = 90;
    localparam logic [31:0] TIME_MAX     = 32'hFFFF_FFFF;

    // one expected result of a request
    typedef struct packed {
        logic [stq_pkg::HANDLE_W-1:0] handle;
        stq_pkg::status_t             status;
        logic                         last;
    } timer_result_t;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          cmd_valid     = 1'b0;
    logic                          cmd_ready;
    logic [1:0]                    operation     = stq_pkg::OP_TICK;
    logic [stq_pkg::HANDLE_W-1:0]  timer_handle  = '0;
    logic [stq_pkg::IN_TIME_W-1:0] expire_time   = '0;
    logic [stq_pkg::IN_TIME_W-1:0] now_time      = '0;
    logic                          result_valid;
    logic                          result_ready  = 1'b0;
    logic [stq_pkg::HANDLE_W-1:0]  result_handle;
    logic [2:0]                    status;
    logic                          last;

    // idle and stall rates in percent, changed per phase
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   error_count    = 0;
    int                   quiet_cycles   = 0;
    // low end of the narrow expiry window, so that equal expiries are common
    logic [31:0]          time_base      = 32'd1000;

    // timer list as the block should hold it: ascending expiry, ties in arrival order
    logic [stq_pkg::HANDLE_W-1:0] list_handle [LIST_DEPTH];
    logic [31:0]                  list_expiry [LIST_DEPTH];
    bit                           handle_busy [stq_pkg::NUM_HANDLES];
    int                           list_count     = 0;
    timer_result_t                pending_results [$];

    sorted_timer_queue u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .operation     (operation),
        .timer_handle  (timer_handle),
        .expire_time   (expire_time),
        .now_time      (now_time),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_handle (result_handle),
        .status        (status),
        .last          (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // list model
    // ------------------------------------------------------------------

    task automatic push_result(input logic [stq_pkg::HANDLE_W-1:0] h,
                               input stq_pkg::status_t st, input logic is_last);
        timer_result_t r;
        r.handle = h;
        r.status = st;
        r.last   = is_last;
        pending_results.push_back(r);
    endtask

    // new timer goes behind every entry whose expiry is lower or equal
    task automatic list_insert(input logic [stq_pkg::HANDLE_W-1:0] h,
                               input logic [31:0] t);
        int pos;
        int i;
        pos = 0;
        while (pos < list_count && list_expiry[pos] <= t)
            pos++;
        for (i = list_count; i > pos; i--)
        begin
            list_handle[i] = list_handle[i - 1];
            list_expiry[i] = list_expiry[i - 1];
        end
        list_handle[pos] = h;
        list_expiry[pos] = t;
        list_count++;
        handle_busy[h] = 1'b1;
    endtask

    task automatic list_remove(input logic [stq_pkg::HANDLE_W-1:0] h);
        int pos;
        int i;
        pos = 0;
        while (pos < list_count && list_handle[pos] != h)
            pos++;
        if (pos < list_count)
        begin
            for (i = pos; i + 1 < list_count; i++)
            begin
                list_handle[i] = list_handle[i + 1];
                list_expiry[i] = list_expiry[i + 1];
            end
            list_count--;
            handle_busy[h] = 1'b0;
        end
    endtask

    // applies one accepted request to the list and queues the results it must give
    task automatic predict_request(input stq_pkg::op_t op,
                                   input logic [stq_pkg::HANDLE_W-1:0] h,
                                   input logic [31:0] et, input logic [31:0] nt);
        int due;
        int i;
        case (op) inside
            stq_pkg::OP_ADD:
            begin
                // duplicate is checked first; with 16 handles and 16 slots a full
                // list means every handle is busy, so full never shows here
                if (handle_busy[h])
                    push_result(h, stq_pkg::STATUS_DUP, 1'b1);
                else if (list_count >= LIST_DEPTH)
                    push_result(h, stq_pkg::STATUS_FULL, 1'b1);
                else
                begin
                    list_insert(h, et);
                    push_result(h, stq_pkg::STATUS_DONE, 1'b1);
                end
            end
            stq_pkg::OP_ADJUST, stq_pkg::OP_DELETE:
            begin
                if (!handle_busy[h])
                    push_result(h, stq_pkg::STATUS_UNKNOWN, 1'b1);
                else
                begin
                    // adjust is a remove plus a fresh insert
                    list_remove(h);
                    if (op == stq_pkg::OP_ADJUST)
                        list_insert(h, et);
                    push_result(h, stq_pkg::STATUS_DONE, 1'b1);
                end
            end
            default:
            begin
                due = 0;
                while (due < list_count && list_expiry[due] <= nt)
                    due++;
                if (due == 0)
                    push_result('0, stq_pkg::STATUS_NONE, 1'b1);
                else
                begin
                    for (i = 0; i < due; i++)
                    begin
                        push_result(list_handle[i], stq_pkg::STATUS_EXPIRED, i == due - 1);
                        handle_busy[list_handle[i]] = 1'b0;
                    end
                    for (i = 0; i + due < list_count; i++)
                    begin
                        list_handle[i] = list_handle[i + due];
                        list_expiry[i] = list_expiry[i + due];
                    end
                    list_count -= due;
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // valid stays high from one request into the next when no gap is drawn,
    // so it is only lowered at the start of a gap
    task automatic send_request(input stq_pkg::op_t op,
                                input logic [stq_pkg::HANDLE_W-1:0] h,
                                input logic [31:0] et, input logic [31:0] nt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid    <= 1'b1;
        operation    <= op;
        timer_handle <= h;
        expire_time  <= et;
        now_time     <= nt;
        @(posedge clk);
        while (cmd_ready !== 1'b1)
            @(posedge clk);
        predict_request(op, h, et, nt);
    endtask

    // a handle that is queued or free as asked, from a random start; any if none fits
    function automatic logic [stq_pkg::HANDLE_W-1:0] pick_handle(input bit want_busy);
        logic [stq_pkg::HANDLE_W-1:0] h;
        h = 4'($urandom_range(15));
        repeat (stq_pkg::NUM_HANDLES)
        begin
            if (handle_busy[h] == want_busy)
                return h;
            h = h + 1'b1;
        end
        return h;
    endfunction

    // mostly a narrow window for ties, sometimes the whole range
    function automatic logic [31:0] rand_expiry();
        if ($urandom_range(99) < 70)
            return time_base + 32'($urandom_range(63));
        return $urandom();
    endfunction

    // tick times mostly aimed at listed expiries (one below, equal or one above), else the window or any value
    function automatic logic [31:0] rand_now();
        int roll;
        roll = $urandom_range(99);
        if (list_count > 0 && roll < 60)
            return list_expiry[$urandom_range(list_count - 1)] + 32'($urandom_range(2)) - 32'd1;
        if (roll < 80)
            return time_base + 32'($urandom_range(63));
        return $urandom();
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic report_mismatch(input string msg);
        if (error_count < 100)
            $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        timer_result_t want;
        if (rst_n && result_valid === 1'b1 && result_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result handle %0d status %0d last %0d",
                                          result_handle, status, last));
            else
            begin
                want = pending_results.pop_front();
                if (result_handle !== want.handle)
                    report_mismatch($sformatf("result_handle %0d, want %0d",
                                              result_handle, want.handle));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %s (handle %0d)",
                                              status, want.status.name(), want.handle));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0d, want %0d (handle %0d)",
                                              last, want.last, want.handle));
            end
        end
    end

    // hang detector: counts cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL sorted_timer_queue");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // tick on an empty list, adjust and delete of handles never added
    task automatic test_empty_list();
        send_request(stq_pkg::OP_TICK, 4'd0, 32'd0, TIME_MAX);
        send_request(stq_pkg::OP_ADJUST, 4'd3, 32'h55, 32'd0);
        send_request(stq_pkg::OP_DELETE, 4'd12, 32'd0, 32'd0);
    endtask

    // extreme expiries, a duplicate add and three equal expiries kept in order
    task automatic test_add_order();
        send_request(stq_pkg::OP_ADD, 4'd0, 32'd0, TIME_MAX);
        send_request(stq_pkg::OP_ADD, 4'd15, TIME_MAX, 32'd0);
        send_request(stq_pkg::OP_ADD, 4'd0, 32'd5, 32'd0);
        send_request(stq_pkg::OP_ADD, 4'd5, 32'd100, 32'd0);
        send_request(stq_pkg::OP_ADD, 4'd6, 32'd100, 32'd0);
        send_request(stq_pkg::OP_ADD, 4'd7, 32'd100, 32'd0);
    endtask

    // adjust to an equal, a lower and a higher expiry, then deletes
    task automatic test_adjust_delete();
        send_request(stq_pkg::OP_ADJUST, 4'd5, 32'd100, 32'd0);
        send_request(stq_pkg::OP_ADJUST, 4'd7, 32'd1, 32'd0);
        send_request(stq_pkg::OP_ADJUST, 4'd0, 32'd300, 32'd0);
        send_request(stq_pkg::OP_DELETE, 4'd6, 32'd0, 32'd0);
        send_request(stq_pkg::OP_DELETE, 4'd6, 32'd0, 32'd0);
    endtask

    // nothing due, two due, one short of the top time, the top time, empty again
    task automatic test_tick_pops();
        send_request(stq_pkg::OP_TICK, 4'd0, 32'd0, 32'd0);
        send_request(stq_pkg::OP_TICK, 4'd0, 32'd0, 32'd100);
        send_request(stq_pkg::OP_TICK, 4'd0, 32'd0, TIME_MAX - 32'd1);
        send_request(stq_pkg::OP_TICK, 4'd0, 32'd0, TIME_MAX);
        send_request(stq_pkg::OP_TICK, 4'd15, TIME_MAX, 32'd0);
    endtask

    // mixed traffic that mostly names sensible handles, with some misses
    task automatic test_random_traffic(input int n_items);
        int                           roll;
        logic [stq_pkg::HANDLE_W-1:0] h;
        stq_pkg::op_t                 op;
        repeat (n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 35)
            begin
                h = ($urandom_range(99) < 80) ? pick_handle(1'b0) : 4'($urandom_range(15));
                send_request(stq_pkg::OP_ADD, h, rand_expiry(), $urandom());
            end
            else if (roll < 70)
            begin
                h = ($urandom_range(99) < 85) ? pick_handle(1'b1) : 4'($urandom_range(15));
                if (roll < 55)
                    op = stq_pkg::OP_ADJUST;
                else
                    op = stq_pkg::OP_DELETE;
                send_request(op, h, rand_expiry(), $urandom());
            end
            else
                send_request(stq_pkg::OP_TICK, 4'($urandom_range(15)), $urandom(), rand_now());
        end
    endtask

    // fill every slot, try one more add, then expire the whole list in one tick
    task automatic test_fill_and_flush();
        while (list_count < LIST_DEPTH)
            send_request(stq_pkg::OP_ADD, pick_handle(1'b0), rand_expiry(), $urandom());
        send_request(stq_pkg::OP_ADD, 4'($urandom_range(15)), rand_expiry(), $urandom());
        send_request(stq_pkg::OP_TICK, 4'($urandom_range(15)), $urandom(), TIME_MAX);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        time_base      = $urandom();
        test_random_traffic(PHASE_ITEMS);
        test_fill_and_flush();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_add_order();
        test_adjust_delete();
        test_tick_pops();

        // no idling, sender gaps, receiver stalls, then light idling on both
        test_random_phase(0, 0);
        test_random_phase(70, 0);
        test_random_phase(0, 70);
        test_random_phase(8, 8);

        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASS sorted_timer_queue");
        else
            $display("FAIL sorted_timer_queue");
        $finish;
    end

endmodule
